/* hw/rtl/kct_pkg.sv */
// Shared types and constants for the keyed contact table.
// Used by the channel interfaces and the top level.
package kct_pkg;

    localparam int KEY_BYTES = 32;
    localparam int KEY_W     = KEY_BYTES * 8;
    localparam int NAME_W    = 128;
    localparam int STAMP_W   = 32;
    localparam int CAP_W     = 7;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_UPSERT = 2'd1,
        ACT_SCAN   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_RDATA,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_action      action;
        logic [63:0]  key_w0;
        logic [63:0]  key_w1;
        logic [63:0]  key_w2;
        logic [63:0]  key_w3;
        logic         has_name;
        logic [63:0]  name_lo;
        logic [63:0]  name_hi;
        logic [31:0]  last_seen;
        logic [7:0]   hash;
        logic [6:0]   cursor;
    } t_req;

    typedef struct packed {
        logic         status;
        logic [5:0]   index;
        logic [6:0]   cursor_next;
        logic [31:0]  stamp_out;
        logic [63:0]  name_out_lo;
        logic [63:0]  name_out_hi;
    } t_rsp;

endpackage

/* hw/rtl/kct_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on kct_pkg for the payload types.
interface kct_req_if import kct_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kct_rsp_if import kct_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/kct_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* hw/rtl/keyed_contact_table.sv */
// Keyed contact table top level: request sequencer, entry memories, response register.
// Depends on kct_pkg, kct_req_if / kct_rsp_if and kct_ram.
//
//  channel   dir  handshake          payload
//  -------   ---  ---------          -------
//  i_req     in   valid / ready      action, key words, name words, stamp, hash, cursor
//  o_rsp     out  valid / ready      status, index, cursor_next, stamp, name words
//  i_cfg     in   write enable only  capacity_limit (7 bits)
//
// One request is handled at a time. Clear goes from the start state straight to the
// response state, read passes through the data state when its cursor is in range, and
// upsert and scan walk the stored entries in the scan state; the key memory delivers
// one stored key per cycle. Reset (synchronous, active low) empties the table by
// clearing the entry count; the memories are not swept, so no sweep follows reset.
// A new request is taken whenever the sequencer is idle, even while a response still
// waits in the output register; a finished request then holds until that register frees.
module keyed_contact_table import kct_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_BYTES  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    kct_req_if.sink          i_req,
    kct_rsp_if.source        o_rsp
);
    // Entry index width, entry count width, and a width that holds both the
    // count and a 7-bit cursor for comparisons.
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;

    // Copy name bytes up to the first zero byte, at most nb-1 of them; the rest
    // stay zero so the stored name is always terminated.
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] src,
                                                     input int nb);
        logic [NAME_W-1:0] res;
        logic              ended;
        logic [7:0]        b;
        res   = '0;
        ended = 1'b0;
        for (int k = 0; k < NAME_W / 8; k++) begin
            b = src[k*8 +: 8];
            if (k >= nb - 1 || b == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                res[k*8 +: 8] = b;
            end
        end
        return res;
    endfunction

    t_state              r_state, n_state;
    t_action             r_act;
    logic [KEY_W-1:0]    r_key;
    logic                r_has_name;
    logic [NAME_W-1:0]   r_name;
    logic [STAMP_W-1:0]  r_stamp_in;
    logic [7:0]          r_hash;
    logic [6:0]          r_cur;

    logic [CW-1:0]       r_count, n_count;
    logic [CAP_W-1:0]    r_cap;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic                r_issue, n_issue;
    logic [IW-1:0]       r_iaddr, n_iaddr;
    t_rsp                r_res, n_res;
    t_rsp                r_out;
    logic                r_ov;

    // Memory ports.
    logic                key_we, stamp_we, name_we;
    logic [IW-1:0]       waddr;
    logic [IW-1:0]       key_raddr, ent_raddr;
    logic [KEY_W-1:0]    key_rdata;
    logic [STAMP_W-1:0]  stamp_rdata;
    logic [NAME_W-1:0]   name_rdata;

    logic                accept;
    logic                resp_load;
    logic [WW-1:0]       limit_w;
    logic                table_full;
    logic                cur_in_range;
    logic                ptr_in_range;
    logic                key_match;
    logic                scan_hit;
    logic                scan_miss;

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign resp_load = (r_state == ST_RESP) && (!r_ov || o_rsp.ready);

    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    // The limit in force is the smaller of the register and the table size.
    assign limit_w = (WW'(r_cap) < WW'(MAX_ENTRIES)) ? WW'(r_cap) : WW'(MAX_ENTRIES);
    assign table_full   = (WW'(r_count) >= limit_w);
    assign cur_in_range = (WW'(r_cur) < WW'(r_count));
    assign ptr_in_range = (r_ptr < r_count);

    // The key read issued last cycle comes back now; upsert needs the whole
    // key, the scan only byte 0.
    assign key_match = (r_act == ACT_UPSERT) ? (key_rdata == r_key)
                                             : (key_rdata[7:0] == r_hash);
    assign scan_hit  = r_issue && key_match;
    assign scan_miss = !r_issue && !ptr_in_range;

    assign key_raddr = IW'(r_ptr);
    assign ent_raddr = IW'(r_cur);

    kct_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    kct_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (waddr),
        .i_wdata (r_stamp_in),
        .i_raddr (ent_raddr),
        .o_rdata (stamp_rdata)
    );

    kct_ram #(.WIDTH(NAME_W), .DEPTH(MAX_ENTRIES)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (waddr),
        .i_wdata (r_has_name ? r_name : '0),
        .i_raddr (ent_raddr),
        .o_rdata (name_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                case (r_act)
                    ACT_CLEAR:  n_state = ST_RESP;
                    ACT_READ:   n_state = cur_in_range ? ST_RDATA : ST_RESP;
                    ACT_UPSERT: n_state = ST_SCAN;
                    ACT_SCAN:   n_state = ST_SCAN;
                    default:    n_state = ST_RESP;
                endcase
            end
            ST_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = ST_RESP;
                end
            end
            ST_RDATA: n_state = ST_RESP;
            ST_RESP: begin
                if (resp_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath controls, memory writes and the pending result.
    always_comb begin
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_issue  = r_issue;
        n_iaddr  = r_iaddr;
        n_res    = r_res;
        key_we   = 1'b0;
        stamp_we = 1'b0;
        name_we  = 1'b0;
        waddr    = IW'(r_count);
        case (r_state)
            ST_START: begin
                n_res   = '0;
                n_issue = 1'b0;
                case (r_act)
                    ACT_CLEAR: begin
                        n_count = '0;
                    end
                    ACT_READ: begin
                        n_res.status = !cur_in_range;
                    end
                    ACT_UPSERT: begin
                        n_ptr = '0;
                    end
                    ACT_SCAN: begin
                        // A cursor at or past the count walks nothing.
                        n_ptr = cur_in_range ? CW'(r_cur) : r_count;
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_res.index = 6'(r_iaddr);
                    if (r_act == ACT_SCAN) begin
                        n_res.cursor_next = 7'(CW'(r_iaddr) + CW'(1));
                    end else begin
                        waddr    = r_iaddr;
                        stamp_we = 1'b1;
                        name_we  = r_has_name;
                    end
                end else if (scan_miss) begin
                    if (r_act == ACT_SCAN) begin
                        n_res.status      = 1'b1;
                        n_res.cursor_next = 7'(r_count);
                    end else if (table_full) begin
                        n_res.status = 1'b1;
                    end else begin
                        // Append at the end of the filled region.
                        key_we      = 1'b1;
                        stamp_we    = 1'b1;
                        name_we     = 1'b1;
                        n_res.index = 6'(r_count);
                        n_count     = r_count + CW'(1);
                    end
                end else begin
                    // Keep one key read in flight per cycle.
                    n_issue = ptr_in_range;
                    n_iaddr = IW'(r_ptr);
                    if (ptr_in_range) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            ST_RDATA: begin
                n_res.index       = 6'(r_cur);
                n_res.stamp_out   = stamp_rdata;
                n_res.name_out_lo = name_rdata[63:0];
                n_res.name_out_hi = name_rdata[127:64];
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_W'(64);
            r_issue <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (resp_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_iaddr <= n_iaddr;
        r_res   <= n_res;
        if (resp_load) begin
            r_out <= r_res;
        end
        if (accept) begin
            r_act      <= i_req.data.action;
            r_key      <= {i_req.data.key_w3, i_req.data.key_w2,
                           i_req.data.key_w1, i_req.data.key_w0};
            r_has_name <= i_req.data.has_name;
            r_name     <= clean_name({i_req.data.name_hi, i_req.data.name_lo}, NAME_BYTES);
            r_stamp_in <= i_req.data.last_seen;
            r_hash     <= i_req.data.hash;
            r_cur      <= i_req.data.cursor;
        end
    end

endmodule
